>>> src/rbd_pkg.sv
// Shared constants, codes and types for the ring buffer deque.
`default_nettype none

package rbd_pkg;

	// Storage geometry.
	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// Item field widths.
	localparam int MODE_W   = 3;
	localparam int STATUS_W = 2;
	localparam int IN_TDATA_W  = ((DATA_W + 7) / 8) * 8;
	localparam int OUT_BITS    = 2 * DATA_W + CNT_W + 1;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Operation codes carried in the input item.
	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd4;
	localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd5;

	// Status codes returned with each result.
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_UNDER = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OVER  = 2'd2;

	// Per-cell command from the controller.
	typedef struct packed {
		logic load;      // take the pushed word
		logic shift_r;   // take the word of the cell toward the front
		logic shift_l;   // take the word of the cell toward the rear
	} cell_ctl_t;

endpackage

`default_nettype wire

>>> src/rbd_cell.sv
// One storage cell of the deque chain, holding one word.
`default_nettype none

module rbd_cell (
	input  wire                        clk,
	input  wire rbd_pkg::cell_ctl_t    ctl,
	input  wire  [rbd_pkg::DATA_W-1:0] push_word,
	input  wire  [rbd_pkg::DATA_W-1:0] left_word,
	input  wire  [rbd_pkg::DATA_W-1:0] right_word,
	output logic [rbd_pkg::DATA_W-1:0] word_q,
	output logic [rbd_pkg::DATA_W-1:0] word_d
);

	// Select the next content of this cell.
	always_comb begin
		priority if (ctl.load) begin
			word_d = push_word;
		end else if (ctl.shift_r) begin
			word_d = left_word;
		end else if (ctl.shift_l) begin
			word_d = right_word;
		end else begin
			word_d = word_q;
		end
	end

	// Payload register; no reset needed.
	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

endmodule

`default_nettype wire

>>> src/ring_buffer_deque.sv
// Top level of the double-ended queue built from a chain of word cells.
//
//  Channel  Direction  tdata (low bit first)                          tuser
//  s_axis   in         data_in[31:0]                                  mode[2:0]
//  m_axis   out        front_value, rear_value, count, is_empty, pad  status[1:0]
//
// The front word always sits in cell 0 and the words lie in order along the chain,
// so a push at the front or a pop from the front shifts every cell by one place.
// One item is taken per cycle; its result is registered and shows in the next cycle.
// The result register sets the rate: a new item is taken while it is empty or drained.
// Reset clears the count and the result valid; cell contents are left undefined.
// A stall on m_axis holds the result and blocks s_axis until it is taken.
`default_nettype none

module ring_buffer_deque (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire  [rbd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // data_in[31:0]
	input  wire  [rbd_pkg::MODE_W-1:0]          s_axis_tuser,  // mode[2:0]
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	output logic [rbd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // front_value[31:0],
	                                            // rear_value[63:32], count[68:64],
	                                            // is_empty[69], zero pad[71:70]
	output logic [rbd_pkg::STATUS_W-1:0]        m_axis_tuser   // status[1:0]
);

	localparam int DEPTH  = rbd_pkg::DEPTH;
	localparam int DATA_W = rbd_pkg::DATA_W;
	localparam int IDX_W  = rbd_pkg::IDX_W;
	localparam int CNT_W  = rbd_pkg::CNT_W;

	logic [CNT_W-1:0]              count_q;
	logic [CNT_W-1:0]              count_d;
	logic [DATA_W-1:0]             cell_q [DEPTH];
	logic [DATA_W-1:0]             cell_d [DEPTH];
	rbd_pkg::cell_ctl_t            ctl [DEPTH];

	logic                          accept;
	logic [rbd_pkg::MODE_W-1:0]    mode;
	logic [DATA_W-1:0]             push_word;
	logic                          is_push;
	logic                          is_pop;
	logic                          full;
	logic                          empty;
	logic                          push_ok;
	logic                          pop_ok;
	logic [rbd_pkg::STATUS_W-1:0]  status;
	logic [IDX_W-1:0]              rear_pos;
	logic [DATA_W-1:0]             front_word;
	logic [DATA_W-1:0]             rear_word;

	// Input handshake and decode.
	assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign mode          = s_axis_tuser;
	assign push_word     = s_axis_tdata[DATA_W-1:0];

	assign is_push = (mode == rbd_pkg::MODE_PUSH_FRONT) || (mode == rbd_pkg::MODE_PUSH_REAR);
	assign is_pop  = (mode == rbd_pkg::MODE_POP_FRONT) || (mode == rbd_pkg::MODE_POP_REAR);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign push_ok = accept && is_push && !full;
	assign pop_ok  = accept && is_pop && !empty;

	// Status of the current item.
	always_comb begin
		if (is_push && full) begin
			status = rbd_pkg::STATUS_OVER;
		end else if (is_pop && empty) begin
			status = rbd_pkg::STATUS_UNDER;
		end else begin
			status = rbd_pkg::STATUS_OK;
		end
	end

	// Next word count.
	always_comb begin
		if (accept && (mode == rbd_pkg::MODE_CLEAR)) begin
			count_d = '0;
		end else if (push_ok) begin
			count_d = count_q + CNT_W'(1);
		end else if (pop_ok) begin
			count_d = count_q - CNT_W'(1);
		end else begin
			count_d = count_q;
		end
	end

	// The chain of cells with their commands and neighbor links.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] left_word;
		logic [DATA_W-1:0] right_word;

		always_comb begin
			ctl[i].load    = push_ok &&
			                 (((mode == rbd_pkg::MODE_PUSH_FRONT) && (i == 0)) ||
			                  ((mode == rbd_pkg::MODE_PUSH_REAR) &&
			                   (count_q == CNT_W'(i))));
			ctl[i].shift_r = push_ok && (mode == rbd_pkg::MODE_PUSH_FRONT) && (i != 0);
			ctl[i].shift_l = pop_ok && (mode == rbd_pkg::MODE_POP_FRONT);
		end

		if (i == 0) begin : g_first
			assign left_word = '0;
		end else begin : g_inner_l
			assign left_word = cell_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_word = '0;
		end else begin : g_inner_r
			assign right_word = cell_q[i+1];
		end

		rbd_cell u_cell (
			.clk        (clk),
			.ctl        (ctl[i]),
			.push_word  (push_word),
			.left_word  (left_word),
			.right_word (right_word),
			.word_q     (cell_q[i]),
			.word_d     (cell_d[i])
		);
	end

	// Front and rear words after the operation.
	assign rear_pos   = IDX_W'(count_d - CNT_W'(1));
	assign front_word = (count_d == '0) ? '1 : cell_d[0];
	assign rear_word  = (count_d == '0) ? '1 : cell_d[rear_pos];

	// Count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// Result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (s_axis_tready) begin
			m_axis_tvalid <= accept;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			m_axis_tdata <= rbd_pkg::OUT_TDATA_W'({(count_d == '0), count_d, rear_word,
				front_word});
			m_axis_tuser <= status;
		end
	end

endmodule

`default_nettype wire

>>> sim/tb_ring_buffer_deque.sv
// Self-checking testbench for the ring buffer deque.
`timescale 1ns / 1ps

module tb_ring_buffer_deque;

	// Geometry taken from the shared package.
	localparam int DEPTH    = rbd_pkg::DEPTH;
	localparam int DATA_W   = rbd_pkg::DATA_W;
	localparam int IDX_W    = rbd_pkg::IDX_W;
	localparam int CNT_W    = rbd_pkg::CNT_W;
	localparam int MODE_W   = rbd_pkg::MODE_W;
	localparam int STATUS_W = rbd_pkg::STATUS_W;

	// Mode codes that the block treats as a plain query.
	localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

	// Data corner values.
	localparam logic [DATA_W-1:0] WORD_MIN  = 32'h8000_0000;
	localparam logic [DATA_W-1:0] WORD_MAX  = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] WORD_ZERO = 32'h0000_0000;
	localparam logic [DATA_W-1:0] WORD_ONES = 32'hffff_ffff;

	// One result as seen on the output stream.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DATA_W-1:0]   front;
		logic [DATA_W-1:0]   rear;
		logic [CNT_W-1:0]    count;
		logic                is_empty;
	} deque_view_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // data_in[31:0]
	logic [2:0]  s_axis_tuser = '0;   // mode[2:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;        // front_value, rear_value, count, is_empty, pad
	logic [1:0]  m_axis_tuser;        // status[1:0]

	ring_buffer_deque i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #1 clk = ~clk;

	// Shadow copy of the deque contents.
	logic [DATA_W-1:0] dq_store [DEPTH];
	logic [IDX_W-1:0]  dq_head = '0;
	logic [IDX_W-1:0]  dq_tail = '0;
	logic [CNT_W-1:0]  dq_count = '0;

	deque_view_t expected_views[$];

	// Run statistics and control shared by the processes.
	int  mismatches = 0;
	int  items_sent = 0;
	int  n_push = 0, n_pop = 0, n_under = 0, n_over = 0, n_clear = 0, n_query = 0;
	int  peak_count = 0;
	bit  gaps_on = 1'b1;
	bit  stall_req = 1'b0;
	bit  stall_seen = 1'b0;
	int  stall_len = 0;

	// Apply one operation to the shadow deque and return what the block should show.
	function automatic deque_view_t apply_op(input logic [MODE_W-1:0] op,
			input logic [DATA_W-1:0] word);
		deque_view_t v;
		v.status = rbd_pkg::STATUS_OK;
		case (op)
			rbd_pkg::MODE_PUSH_FRONT, rbd_pkg::MODE_PUSH_REAR: begin
				n_push++;
				if (dq_count >= CNT_W'(DEPTH)) begin
					v.status = rbd_pkg::STATUS_OVER;
					n_over++;
				end else if (dq_count == '0) begin
					// First word lands at the head and both ends point at it.
					dq_store[dq_head] = word;
					dq_tail = dq_head;
					dq_count = CNT_W'(1);
				end else if (op == rbd_pkg::MODE_PUSH_FRONT) begin
					dq_head = (dq_head == '0) ? IDX_W'(DEPTH - 1) : dq_head - IDX_W'(1);
					dq_store[dq_head] = word;
					dq_count++;
				end else begin
					dq_tail = (dq_tail == IDX_W'(DEPTH - 1)) ? '0 : dq_tail + IDX_W'(1);
					dq_store[dq_tail] = word;
					dq_count++;
				end
			end
			rbd_pkg::MODE_POP_FRONT, rbd_pkg::MODE_POP_REAR: begin
				n_pop++;
				if (dq_count == '0) begin
					v.status = rbd_pkg::STATUS_UNDER;
					n_under++;
				end else begin
					// Popping the last word leaves the indices where they are.
					if (dq_count > CNT_W'(1)) begin
						if (op == rbd_pkg::MODE_POP_FRONT)
							dq_head = (dq_head == IDX_W'(DEPTH - 1)) ? '0 :
								dq_head + IDX_W'(1);
						else
							dq_tail = (dq_tail == '0) ? IDX_W'(DEPTH - 1) :
								dq_tail - IDX_W'(1);
					end
					dq_count--;
				end
			end
			rbd_pkg::MODE_CLEAR: begin
				n_clear++;
				dq_head = '0;
				dq_tail = '0;
				dq_count = '0;
			end
			default: n_query++;
		endcase
		if (int'(dq_count) > peak_count)
			peak_count = int'(dq_count);
		v.count    = dq_count;
		v.is_empty = (dq_count == '0);
		v.front    = (dq_count == '0) ? WORD_ONES : dq_store[dq_head];
		v.rear     = (dq_count == '0) ? WORD_ONES : dq_store[dq_tail];
		return v;
	endfunction

	// Offer one item, wait for the handshake and record the expected result.
	task automatic send_item(input logic [MODE_W-1:0] op, input logic [DATA_W-1:0] word);
		int gap;
		gap = gaps_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= word;
		do
			@(posedge clk);
		while (!s_axis_tready);
		expected_views.push_back(apply_op(op, word));
		items_sent++;
	endtask

	function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Receiver: per-item wait, optional long hold-off, and the result check.
	int rx_wait = 0;
	int rx_hold = 0;
	always @(posedge clk) begin
		deque_view_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_views.size() == 0) begin
				$error("result with no expectation waiting: tdata %0h tuser %0h",
					m_axis_tdata, m_axis_tuser);
				mismatches++;
			end else begin
				want = expected_views.pop_front();
				check_field("status", DATA_W'(want.status), DATA_W'(m_axis_tuser));
				check_field("front_value", want.front, m_axis_tdata[31:0]);
				check_field("rear_value", want.rear, m_axis_tdata[63:32]);
				check_field("count", DATA_W'(want.count), DATA_W'(m_axis_tdata[68:64]));
				check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(m_axis_tdata[69]));
			end
			rx_wait = gaps_on ? $urandom_range(0, 5) : 0;
		end
		if (stall_req != stall_seen) begin
			stall_seen = stall_req;
			rx_hold = stall_len;
		end
		if (rx_hold > 0) begin
			rx_hold--;
			m_axis_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(0, 15))
			0:       return WORD_MIN;
			1:       return WORD_MAX;
			2:       return WORD_ZERO;
			3:       return WORD_ONES;
			default: return $urandom;
		endcase
	endfunction

	// Push with the given percentage, otherwise pop; clears and queries now and then.
	function automatic logic [MODE_W-1:0] pick_mode(input int push_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 2)
			return rbd_pkg::MODE_CLEAR;
		if (r < 4)
			return rbd_pkg::MODE_QUERY;
		if (r == 4)
			return MODE_SPARE_6;
		if (r == 5)
			return MODE_SPARE_7;
		if ($urandom_range(0, 99) < push_pct)
			return $urandom_range(0, 1) ? rbd_pkg::MODE_PUSH_REAR : rbd_pkg::MODE_PUSH_FRONT;
		return $urandom_range(0, 1) ? rbd_pkg::MODE_POP_REAR : rbd_pkg::MODE_POP_FRONT;
	endfunction

	// Pops, queries and clear on an empty deque, spare codes included.
	task automatic test_empty_deque();
		send_item(rbd_pkg::MODE_POP_FRONT, WORD_ONES);
		send_item(rbd_pkg::MODE_POP_REAR, WORD_MIN);
		send_item(rbd_pkg::MODE_QUERY, WORD_MAX);
		send_item(MODE_SPARE_6, WORD_ZERO);
		send_item(MODE_SPARE_7, WORD_ONES);
		send_item(rbd_pkg::MODE_CLEAR, WORD_MAX);
	endtask

	// Push onto empty, then pop the only word.
	task automatic test_single_word();
		send_item(rbd_pkg::MODE_PUSH_FRONT, WORD_MIN);
		send_item(rbd_pkg::MODE_POP_REAR, WORD_ZERO);
	endtask

	// Fill from both ends with corner data, push past full, then clear.
	task automatic test_fill_and_overflow();
		for (int i = 0; i < DEPTH; i++)
			send_item(i[0] ? rbd_pkg::MODE_PUSH_FRONT : rbd_pkg::MODE_PUSH_REAR,
				(i % 4 == 0) ? WORD_MAX : (i % 4 == 1) ? WORD_MIN :
				(i % 4 == 2) ? WORD_ONES : $urandom);
		send_item(rbd_pkg::MODE_PUSH_FRONT, WORD_MAX);
		send_item(rbd_pkg::MODE_PUSH_REAR, WORD_MIN);
		send_item(rbd_pkg::MODE_CLEAR, WORD_ZERO);
	endtask

	// Bursts that lean toward filling or draining, so both ends are reached often.
	task automatic test_random_traffic(input int n_items);
		int left;
		int push_pct;
		int burst;
		left = n_items;
		while (left > 0) begin
			case ($urandom_range(0, 2))
				0:       push_pct = 80;
				1:       push_pct = 20;
				default: push_pct = 50;
			endcase
			gaps_on = ($urandom_range(0, 3) != 0);
			burst = $urandom_range(10, 40);
			for (int i = 0; i < burst && left > 0; i++, left--)
				send_item(pick_mode(push_pct), pick_word());
		end
		gaps_on = 1'b1;
	endtask

	// Receiver holds off for a long stretch while items keep coming.
	task automatic test_output_stall();
		gaps_on = 1'b0;
		stall_len = 80;
		stall_req = ~stall_req;
		for (int i = 0; i < 40; i++)
			send_item(pick_mode(70), pick_word());
		gaps_on = 1'b1;
	endtask

	initial begin
		int spin;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_deque();
		test_single_word();
		test_fill_and_overflow();
		test_random_traffic(460);
		test_output_stall();
		s_axis_tvalid <= 1'b0;

		// Drain all outstanding results, then watch for strays.
		spin = 0;
		while (expected_views.size() != 0 && spin < 10000) begin
			@(posedge clk);
			spin++;
		end
		if (expected_views.size() != 0) begin
			$error("%0d expected results never arrived", expected_views.size());
			mismatches++;
		end
		repeat (5) @(posedge clk);

		$display("Sent %0d items: %0d pushes, %0d pops, %0d clears, %0d queries.",
			items_sent, n_push, n_pop, n_clear, n_query);
		$display("Saw %0d underflows and %0d overflows; deepest fill %0d of %0d.",
			n_under, n_over, peak_count, DEPTH);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog.
	initial begin
		#1000000;
		$display("simulation failed");
		$finish;
	end

endmodule
